// ===== rtl/msd_pkg.sv =====
// Shared constants and saturating helper for the mean squared displacement core.
// No dependencies.
`default_nettype none
package msd_pkg;

    localparam int MSD_W = 63;
    localparam int POS_W = 32;
    localparam int CNT_STEP_W = 6;  // holds MSD_W - 1

    localparam logic [MSD_W-1:0] MSD_TOP = {MSD_W{1'b1}};

    // Both operands stay at or below MSD_TOP, so a carry out means overflow.
    function automatic logic [MSD_W-1:0] sat_add(input logic [MSD_W-1:0] a,
                                                 input logic [MSD_W-1:0] b);
        logic [MSD_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[MSD_W] ? MSD_TOP : s[MSD_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/msd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module msd_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/msd_div.sv =====
// Restoring divider, one quotient bit per cycle, truncating.
// Depends on msd_pkg.
`default_nettype none
module msd_div #(
    parameter int DW = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [msd_pkg::MSD_W-1:0] i_dividend,
    input  wire logic [DW-1:0]             i_divisor,
    output logic                           o_done,
    output logic      [msd_pkg::MSD_W-1:0] o_quot
);
    logic                              r_run;
    logic                              r_done;
    logic [msd_pkg::CNT_STEP_W-1:0]    r_cnt;
    logic [DW-1:0]                     r_rem;
    logic [DW-1:0]                     r_dvs;
    logic [msd_pkg::MSD_W-1:0]         r_q;
    logic [DW:0]                       rem_sh;
    logic                              fits;
    logic [DW:0]                       rem_sub;

    assign rem_sh  = {r_rem, r_q[msd_pkg::MSD_W-1]};
    assign fits    = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == msd_pkg::CNT_STEP_W'(msd_pkg::MSD_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_run) begin
            r_rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_q   <= {r_q[msd_pkg::MSD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== rtl/mean_squared_displacement_core.sv =====
// Time-averaged mean squared displacement core: top level with sequencer.
// Depends on msd_pkg, msd_ram, msd_div.
//
// channel   direction  handshake                  payload
// request   in         i_start & !o_busy          i_frame i_atom i_pos_x/y/z i_last_item
// result    out        o_valid (one-cycle strobe) o_lag o_msd o_last_result
//
// Loading: the position write and the count read happen at the accepting edge; the next cycle
// writes list and count, with o_busy high, so no new request is taken until that is done.
// A request with i_last_item set starts the walk; o_busy stays high through the strobe
// of the last lag. Lag 0 finishes in S_LAG. Other lags: a setup state; per origin a count
// read and a check, per selected atom a list read, two position reads, then for each of
// the 3 dims subtract / square / accumulate, then a divide for the origin's mean; the final
// mean over origins takes one more divide. Each result strobes in the cycle after its lag finishes.
// Reset is synchronous; count valid bits and frame count clear, RAMs are not cleared.
// The receiver cannot stall; results are not held.
`default_nettype none
module mean_squared_displacement_core #(
    parameter int MAX_FRAMES = 64,
    parameter int MAX_ATOMS  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic [5:0]  i_frame,
    input  wire logic [7:0]  i_atom,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic        i_last_item,
    output logic             o_valid,
    output logic      [5:0]  o_lag,
    output logic      [62:0] o_msd,
    output logic             o_last_result
);
    localparam int FW    = $clog2(MAX_FRAMES);
    localparam int AAW   = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam int CW    = $clog2(MAX_ATOMS + 1);
    localparam int FCW   = $clog2(MAX_FRAMES + 1);
    localparam int DW    = (CW > FCW) ? CW : FCW;
    localparam int DEPTH = MAX_FRAMES * (1 << AAW);
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = msd_pkg::POS_W;
    localparam int MW    = msd_pkg::MSD_W;

    typedef enum logic [15:0] {
        S_LOAD = 16'b0000000000000001,
        S_LAG  = 16'b0000000000000010,
        S_ORG  = 16'b0000000000000100,
        S_AL   = 16'b0000000000001000,
        S_PA   = 16'b0000000000010000,
        S_PB   = 16'b0000000000100000,
        S_PC   = 16'b0000000001000000,
        S_DIF  = 16'b0000000010000000,
        S_SQ   = 16'b0000000100000000,
        S_ACC  = 16'b0000001000000000,
        S_DS1  = 16'b0000010000000000,
        S_DIV1 = 16'b0000100000000000,
        S_DS2  = 16'b0001000000000000,
        S_DIV2 = 16'b0010000000000000,
        S_LD   = 16'b0100000000000000,
        S_CR   = 16'b1000000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out;   // result strobe, in the cycle after the lag finishes

    // per-frame count valid bits, cleared at once; counts live in u_cnt
    logic [MAX_FRAMES-1:0] r_cv;
    logic [FCW-1:0] r_fc;
    logic [FW-1:0]  r_tau;
    logic [FW-1:0]  r_c;
    logic [AAW-1:0] r_a;
    logic [AAW-1:0] r_at;
    logic [FCW-1:0] r_org;
    logic [1:0]     r_k;
    logic [3*PW-1:0] r_p0;
    logic [PW-1:0]  r_mag;
    logic [MW-1:0]  r_sq;
    logic [MW-1:0]  r_sum;
    logic [MW-1:0]  r_total;
    logic [MW-1:0]  r_msd;
    logic           r_last;
    logic [5:0]     r_lag;

    // request held for the count update cycle
    logic [FW-1:0]  r_lf;
    logic [AAW-1:0] r_la;
    logic           r_lok;
    logic           r_llast;

    // load-side decode
    logic           accept;
    logic           frame_ok, atom_ok, load_ok, list_ok;
    logic [FW-1:0]  cnt_idx;
    logic [CW-1:0]  cnt_q;
    logic [CW-1:0]  cnt_rd;
    logic [FW-1:0]  cnt_raddr;
    logic [FCW-1:0] f_plus1;
    logic [FCW-1:0] fc_new;

    assign accept    = i_start && !o_busy;
    assign frame_ok  = {26'd0, i_frame} < 32'(MAX_FRAMES);
    assign atom_ok   = {24'd0, i_atom} < 32'(MAX_ATOMS);
    assign load_ok   = accept && frame_ok && atom_ok;
    assign cnt_raddr = (r_state == S_LOAD) ? i_frame[FW-1:0] : r_c;
    assign cnt_idx   = (r_state == S_LD) ? r_lf : r_c;
    assign cnt_rd    = r_cv[cnt_idx] ? cnt_q : '0;
    assign list_ok   = 32'(cnt_rd) < 32'(MAX_ATOMS);
    assign f_plus1   = FCW'(r_lf) + FCW'(1);
    assign fc_new    = ((r_state == S_LD) && r_lok && (f_plus1 > r_fc)) ? f_plus1 : r_fc;

    // RAM ports
    logic           pos_re, al_re;
    logic [AW-1:0]  pos_raddr, al_raddr;
    logic [3*PW-1:0] pos_rdata;
    logic [AAW-1:0] al_rdata;

    assign al_re     = (r_state == S_AL);
    assign al_raddr  = {r_c, r_a};
    assign pos_re    = (r_state == S_PA) || (r_state == S_PB);
    assign pos_raddr = (r_state == S_PA) ? {r_c, al_rdata}
                                         : {FW'(r_c + r_tau), r_at};

    msd_ram #(.W(3 * PW), .D(DEPTH)) u_pos (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr ({i_frame[FW-1:0], AAW'({24'd0, i_atom})}),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    msd_ram #(.W(AAW), .D(DEPTH)) u_list (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_LD) && r_lok && list_ok),
        .i_waddr ({r_lf, AAW'(cnt_rd)}),
        .i_wdata (r_la),
        .i_re    (al_re),
        .i_raddr (al_raddr),
        .o_rdata (al_rdata)
    );

    msd_ram #(.W(CW), .D(MAX_FRAMES)) u_cnt (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_LD) && r_lok && list_ok),
        .i_waddr (r_lf),
        .i_wdata (cnt_rd + CW'(1)),
        .i_re    (1'b1),
        .i_raddr (cnt_raddr),
        .o_rdata (cnt_q)
    );

    // shared divider: per-origin mean, then mean over origins
    logic          div_start, div_done;
    logic [MW-1:0] div_dvd, div_q;
    logic [DW-1:0] div_dvs;

    assign div_start = (r_state == S_DS1) || (r_state == S_DS2);
    assign div_dvd   = (r_state == S_DS1) ? r_sum : r_total;
    assign div_dvs   = (r_state == S_DS1) ? DW'(cnt_rd) : DW'(r_org);

    msd_div #(.DW(DW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    // difference of the current dimension, saturated, then magnitude
    logic [PW-1:0] p0_k, p1_k, d_sat;
    logic [PW:0]   d_wide;

    always_comb begin
        case (r_k)
            2'd0:    begin p0_k = r_p0[PW-1:0];      p1_k = pos_rdata[PW-1:0];      end
            2'd1:    begin p0_k = r_p0[2*PW-1:PW];   p1_k = pos_rdata[2*PW-1:PW];   end
            default: begin p0_k = r_p0[3*PW-1:2*PW]; p1_k = pos_rdata[3*PW-1:2*PW]; end
        endcase
    end

    assign d_wide = {p1_k[PW-1], p1_k} - {p0_k[PW-1], p0_k};
    always_comb begin
        if (d_wide[PW] != d_wide[PW-1]) begin
            d_sat = d_wide[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end else begin
            d_sat = d_wide[PW-1:0];
        end
    end

    logic [2*PW-1:0] sq_full;
    logic [MW-1:0]   sum_add;
    logic [CW-1:0]   a_next;
    logic            last_lag;

    assign sq_full  = r_mag * r_mag;
    assign sum_add  = msd_pkg::sat_add(r_sum, r_sq);
    assign a_next   = CW'(r_a) + CW'(1);
    assign last_lag = (FCW'(r_tau) + FCW'(1)) == r_fc;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: if (accept) n_state = S_LD;
            S_LD:   n_state = (r_llast && (fc_new != '0)) ? S_LAG : S_LOAD;
            S_LAG: begin
                if (r_tau != '0) begin
                    n_state = S_CR;
                end else if (last_lag) begin
                    n_state = S_LOAD;
                end
            end
            S_CR:   n_state = S_ORG;
            S_ORG: begin
                if (FCW'(r_c) == r_org) begin
                    n_state = S_DS2;
                end else if (cnt_rd != '0) begin
                    n_state = S_AL;
                end else begin
                    n_state = S_CR;
                end
            end
            S_AL:   n_state = S_PA;
            S_PA:   n_state = S_PB;
            S_PB:   n_state = S_PC;
            S_PC:   n_state = S_DIF;
            S_DIF:  n_state = S_SQ;
            S_SQ:   n_state = S_ACC;
            S_ACC: begin
                if (r_k != 2'd2) begin
                    n_state = S_DIF;
                end else if (a_next < cnt_rd) begin
                    n_state = S_AL;
                end else begin
                    n_state = S_DS1;
                end
            end
            S_DS1:  n_state = S_DIV1;
            S_DIV1: if (div_done) n_state = S_CR;
            S_DS2:  n_state = S_DIV2;
            S_DIV2: if (div_done) n_state = (last_lag ? S_LOAD : S_LAG);
            default: n_state = S_LOAD;
        endcase
    end

    // lag 0 finishes in S_LAG; other lags finish when the final divide is done
    logic lag_end;
    assign lag_end = ((r_state == S_LAG) && (r_tau == '0)) ||
                     ((r_state == S_DIV2) && div_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_out   <= 1'b0;
            r_fc    <= '0;
            r_tau   <= '0;
            r_cv    <= '0;
        end else begin
            r_state <= n_state;
            r_out   <= lag_end;
            if (r_state == S_LOAD) begin
                r_tau <= '0;
            end
            if (r_state == S_LD) begin
                r_fc <= fc_new;
                if (r_llast && (fc_new == '0)) begin
                    r_cv <= '0;
                end else if (r_lok) begin
                    r_cv[r_lf] <= 1'b1;
                end
            end
            if (lag_end) begin
                r_tau <= r_tau + FW'(1);
                if (last_lag) begin
                    r_fc <= '0;
                    r_cv <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lf    <= i_frame[FW-1:0];
            r_la    <= AAW'({24'd0, i_atom});
            r_lok   <= load_ok;
            r_llast <= i_last_item;
        end
        unique case (r_state)
            S_LAG: begin
                r_total <= '0;
                r_c     <= '0;
                r_org   <= r_fc - FCW'(r_tau);
            end
            S_ORG: begin
                r_a   <= '0;
                r_sum <= '0;
                if ((FCW'(r_c) != r_org) && (cnt_rd == '0)) begin
                    r_c <= r_c + FW'(1);
                end
            end
            S_PA:  r_at <= al_rdata;
            S_PB:  r_p0 <= pos_rdata;
            S_PC:  r_k  <= 2'd0;
            S_DIF: r_mag <= d_sat[PW-1] ? (~d_sat + PW'(1)) : d_sat;
            S_SQ:  r_sq  <= sq_full[MW-1:0];
            S_ACC: begin
                r_sum <= sum_add;
                if (r_k != 2'd2) begin
                    r_k <= r_k + 2'd1;
                end else begin
                    r_a <= AAW'(a_next);
                    r_k <= 2'd0;
                end
            end
            S_DIV1: if (div_done) begin
                r_total <= msd_pkg::sat_add(r_total, div_q);
                r_c     <= r_c + FW'(1);
            end
            default: ;
        endcase
        if (lag_end) begin
            r_msd  <= (r_state == S_LAG) ? '0 : div_q;
            r_lag  <= 6'(r_tau);
            r_last <= last_lag;
        end
    end

    assign o_busy        = (r_state != S_LOAD) || r_out;
    assign o_valid       = r_out;
    assign o_lag         = r_lag;
    assign o_msd         = r_msd;
    assign o_last_result = r_out && r_last;

`ifndef SYNTH
    a_lag0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_lag == 6'd0) |-> (o_msd == '0))
        else $error("lag 0 result not zero");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_result |=> !o_busy && !o_valid)
        else $error("block still busy after final lag");
    a_lag_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |=> !o_valid)
        else $error("back-to-back result strobes");
    a_div_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV1) || (r_state == S_DIV2))
        else $error("divider finished outside a wait state");
`endif
endmodule
`default_nettype wire

// ===== tb/msd_checker.sv =====
// Checker for the mean squared displacement core: tracks accepted requests,
// predicts the per-lag msd results and compares the strobed results. Uses msd_pkg.
module msd_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic        [5:0]  i_frame,
    input  logic        [7:0]  i_atom,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic               i_last_item,
    input  logic               i_valid,
    input  logic        [5:0]  i_lag,
    input  logic        [62:0] i_msd,
    input  logic               i_last_result,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NF = 64;
    localparam int NA = 256;
    localparam longint unsigned TOP = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [5:0]                lag;
        logic [msd_pkg::MSD_W-1:0] msd;
        logic                      last;
    } t_lag_result;

    t_lag_result lag_results_q[$];

    logic signed [msd_pkg::POS_W-1:0] px [NF*NA];
    logic signed [msd_pkg::POS_W-1:0] py [NF*NA];
    logic signed [msd_pkg::POS_W-1:0] pz [NF*NA];
    logic [7:0] sel_atoms [NF*NA];
    int sel_cnt [NF];
    int nframes;

    function automatic longint unsigned sq_disp(logic signed [31:0] later,
                                                logic signed [31:0] earlier);
        longint d;
        longint unsigned m;
        d = longint'(later) - longint'(earlier);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        m = (d < 0) ? longint'(-d) : longint'(d);
        return m * m;
    endfunction

    // Operands never exceed TOP, so the 64-bit sum cannot wrap.
    function automatic longint unsigned clip_add(longint unsigned a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > TOP) ? TOP : s;
    endfunction

    function automatic longint unsigned msd_of_lag(int tau);
        longint unsigned total, sum;
        int origins, s0, s1;
        total = 0;
        if (tau == 0 || tau >= nframes) return 0;
        origins = nframes - tau;
        for (int c = 0; c < origins; c++) begin
            if (sel_cnt[c] == 0) continue;  // empty origin adds nothing
            sum = 0;
            for (int a = 0; a < sel_cnt[c] && a < NA; a++) begin
                s0 = c * NA + sel_atoms[c*NA + a];
                s1 = (c + tau) * NA + sel_atoms[c*NA + a];
                sum = clip_add(sum, sq_disp(px[s1], px[s0]));
                sum = clip_add(sum, sq_disp(py[s1], py[s0]));
                sum = clip_add(sum, sq_disp(pz[s1], pz[s0]));
            end
            total = clip_add(total, sum / longint'(sel_cnt[c]));
        end
        return total / longint'(origins);
    endfunction

    task automatic load_request();
        int slot;
        t_lag_result r;
        slot = i_frame * NA + i_atom;
        px[slot] = i_pos_x;
        py[slot] = i_pos_y;
        pz[slot] = i_pos_z;
        if (sel_cnt[i_frame] < NA) begin
            sel_atoms[i_frame*NA + sel_cnt[i_frame]] = i_atom;
            sel_cnt[i_frame]++;
        end
        if (i_frame + 1 > nframes) nframes = i_frame + 1;
        if (i_last_item) begin
            for (int t = 0; t < nframes; t++) begin
                r.lag  = t[5:0];
                r.msd  = msd_of_lag(t);
                r.last = (t + 1 == nframes);
                lag_results_q.push_back(r);
            end
            foreach (sel_cnt[f]) sel_cnt[f] = 0;
            nframes = 0;
        end
    endtask

    initial begin
        o_errors = 0;
        foreach (sel_cnt[f]) sel_cnt[f] = 0;
        nframes = 0;
    end

    always @(posedge i_clk) begin
        t_lag_result e;
        if (i_rst_n) begin
            if (i_valid) begin
                if (lag_results_q.size() == 0) begin
                    $error("unexpected result: lag %0d msd %0h", i_lag, i_msd);
                    o_errors++;
                end else begin
                    e = lag_results_q.pop_front();
                    if (i_lag !== e.lag) begin
                        $error("lag: expected %0d actual %0d", e.lag, i_lag);
                        o_errors++;
                    end
                    if (i_msd !== e.msd) begin
                        $error("msd: expected %0h actual %0h", e.msd, i_msd);
                        o_errors++;
                    end
                    if (i_last_result !== e.last) begin
                        $error("last_result: expected %0b actual %0b", e.last,
                               i_last_result);
                        o_errors++;
                    end
                end
            end
            if (i_start && !i_busy) load_request();
        end
        o_pending = lag_results_q.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the mean squared displacement testbench: clock, reset, request stimulus
// and verdict. Depends on msd_pkg, mean_squared_displacement_core, msd_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 4_000_000;  // cycles

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic        [5:0]  i_frame;
    logic        [7:0]  i_atom;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic               i_last_item;
    logic               o_valid;
    logic        [5:0]  o_lag;
    logic        [62:0] o_msd;
    logic               o_last_result;
    int                 errors, pending;

    int idle_pct;    // sender idle chance per request, in percent
    int sent;        // requests accepted so far
    longint cycles;

    mean_squared_displacement_core i_dut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_frame, .i_atom,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_last_item,
        .o_valid, .o_lag, .o_msd, .o_last_result
    );

    msd_checker i_chk (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_frame, .i_atom,
        .i_pos_x, .i_pos_y, .i_pos_z, .i_last_item,
        .i_valid(o_valid), .i_lag(o_lag), .i_msd(o_msd),
        .i_last_result(o_last_result), .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: a hung core or a lost result ends the run here.
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // One request: optional idle gap, then hold start until the core takes it.
    // Called at a falling edge, returns at a falling edge.
    task automatic send_request(logic [5:0] f, logic [7:0] a, logic signed [31:0] x,
                                logic signed [31:0] y, logic signed [31:0] z,
                                logic last);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start     <= 1'b1;
        i_frame     <= f;
        i_atom      <= a;
        i_pos_x     <= x;
        i_pos_y     <= y;
        i_pos_z     <= z;
        i_last_item <= last;
        do @(posedge i_clk); while (o_busy);
        sent++;
        @(negedge i_clk);
    endtask

    // Coordinate flavors: 0 random trajectory, 1 extremes, 2 all zero.
    localparam int POS_TRAJ = 0;
    localparam int POS_EXTREME = 1;
    localparam int POS_ZERO = 2;

    function automatic logic signed [31:0] pick_coord(int kind, logic signed [31:0] base);
        case (kind)
            POS_ZERO: return '0;
            POS_EXTREME: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return -32'sd1;
                    default: return '0;
                endcase
            end
            default: begin
                if ($urandom_range(3) == 0) return $urandom;
                return base + $signed(32'($urandom_range(131071)) - 32'sd65536);
            end
        endcase
    endfunction

    // One data set: frames first_f..nf-1 each get the same atoms (so no origin
    // reads an unwritten position), plus n_rep repeated atoms, in shuffled order.
    // Leading frames below first_f stay empty. The final request is flagged last.
    task automatic send_set(int nf, int first_f, int n_at, int n_rep, int kind);
        logic [7:0] atoms[$];
        logic [5:0] fq[$];
        logic [7:0] aq[$];
        logic signed [31:0] base [256];
        bit used [256];
        int j, k;
        logic [5:0] tf;
        logic [7:0] ta;
        foreach (base[i]) base[i] = $urandom;
        foreach (used[i]) used[i] = 0;
        if (n_at >= 256) begin
            for (int i = 0; i < 256; i++) atoms.push_back(i[7:0]);
        end else begin
            while (atoms.size() < n_at) begin
                k = $urandom_range(255);
                if (!used[k]) begin
                    used[k] = 1;
                    atoms.push_back(k[7:0]);
                end
            end
        end
        for (int f = first_f; f < nf; f++)
            foreach (atoms[i]) begin
                fq.push_back(f[5:0]);
                aq.push_back(atoms[i]);
            end
        for (int r = 0; r < n_rep; r++) begin
            fq.push_back(6'($urandom_range(nf - 1, first_f)));
            aq.push_back(atoms[$urandom_range(atoms.size() - 1)]);
        end
        for (int i = fq.size() - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tf = fq[i]; fq[i] = fq[j]; fq[j] = tf;
            ta = aq[i]; aq[i] = aq[j]; aq[j] = ta;
        end
        foreach (fq[i])
            send_request(fq[i], aq[i], pick_coord(kind, base[aq[i]]),
                         pick_coord(kind, base[aq[i]] + 32'sd4096),
                         pick_coord(kind, base[aq[i]] - 32'sd4096),
                         i == fq.size() - 1);
    endtask

    initial begin
        int nf;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_frame     = '0;
        i_atom      = '0;
        i_pos_x     = '0;
        i_pos_y     = '0;
        i_pos_z     = '0;
        i_last_item = 1'b0;
        idle_pct    = 0;
        sent        = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single frame (lag zero only), saturating extremes,
        // empty leading origins with repeated atoms, all 64 frames.
        send_set(1, 0, 1, 0, POS_ZERO);
        send_set(3, 0, 2, 0, POS_EXTREME);
        send_set(4, 0, 3, 2, POS_EXTREME);
        send_set(4, 2, 2, 1, POS_TRAJ);
        send_set(64, 0, 1, 0, POS_TRAJ);

        // Random sets in three idle regimes; drain fully between regimes.
        for (int ph = 0; ph < 3; ph++) begin
            idle_pct = (ph == 0) ? 31 : (ph == 1) ? 80 : 0;
            wait (pending == 0);
            @(negedge i_clk);
            for (int goal = sent + 105; sent < goal; ) begin
                nf = ($urandom_range(9) == 0) ? $urandom_range(12, 7) : $urandom_range(1, 6);
                send_set(nf, ($urandom_range(4) == 0) ? $urandom_range(nf - 1) : 0,
                         $urandom_range(1, 4), $urandom_range(2),
                         ($urandom_range(7) == 0) ? POS_EXTREME : POS_TRAJ);
            end
        end
        i_start <= 1'b0;

        wait (pending == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
